// ===== sv/signed_int_to_decimal_ascii_defines.svh =====
// Assertion macros for the signed integer to decimal text block.
// Included by the top level; no other dependencies.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset
`define S2D_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("s2d assertion failed");
// Next-cycle implication, checked while out of reset
`define S2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("s2d assertion failed");
`else
`define S2D_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define S2D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/s2d_pkg.sv =====
// Shared constants and types for the signed integer to decimal text block.
// No dependencies.
`default_nettype none
package s2d_pkg;

  localparam int CHAR_W     = 6;
  localparam int DIGIT_BITS = 4;
  // magnitude bits folded into the BCD register per cycle
  localparam int STEP_BITS  = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_SIGN,
    EM_DIGITS
  } emit_state_t;

endpackage
`default_nettype wire

// ===== sv/s2d_front.sv =====
// Front end: takes input beats, splits them into sign and magnitude and
// queues them in a two-entry FIFO. Depends on s2d_pkg.
`default_nettype none
module s2d_front #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       q_valid,
  input  wire logic                  q_ready,
  output logic                       q_neg,
  output logic [VALUE_BITS-1:0]      q_mag
);
  import s2d_pkg::*;

  localparam int ENT_W = VALUE_BITS + 1;

  logic [ENT_W-1:0]      ent_r [2];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic                  push, pop;

  // classify: sign bit and unsigned magnitude (most negative value wraps right)
  assign neg = in_value[VALUE_BITS-1];
  assign mag = neg ? (~in_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : in_value;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_neg    = ent_r[rd_ptr_r][VALUE_BITS];
  assign q_mag    = ent_r[rd_ptr_r][VALUE_BITS-1:0];

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= {neg, mag};
    end
  end

endmodule
`default_nettype wire

// ===== sv/s2d_bcd.sv =====
// Iterative binary to BCD converter (shift and add-3), STEP_BITS bits per
// cycle; holds the result until the emitter takes it. Depends on s2d_pkg.
`default_nettype none
module s2d_bcd #(
  parameter int VALUE_BITS = 32,
  parameter int NDIG       = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_neg,
  input  wire logic [VALUE_BITS-1:0] in_mag,
  output logic                       dn_valid,
  input  wire logic                  dn_ready,
  output logic                       dn_neg,
  output logic [NDIG*4-1:0]          dn_bcd
);
  import s2d_pkg::*;

  localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int SH_W  = STEPS * STEP_BITS;
  localparam int BCD_W = NDIG * DIGIT_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [SH_W-1:0]  sh_r, sh_nxt;
  logic [BCD_W-1:0] bcd_r, bcd_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [BCD_W-1:0] dab;
  logic             load;

  assign in_ready = !busy_r && (!done_r || dn_ready);
  assign load     = in_valid && in_ready;
  assign dn_valid = done_r;
  assign dn_neg   = neg_r;
  assign dn_bcd   = bcd_r;

  // STEP_BITS rounds of add-3 then shift in the next magnitude bit
  always_comb begin
    dab = bcd_r;
    for (int b = 0; b < STEP_BITS; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (dab[d*DIGIT_BITS +: DIGIT_BITS] >= 4'd5) begin
          dab[d*DIGIT_BITS +: DIGIT_BITS] = dab[d*DIGIT_BITS +: DIGIT_BITS] + 4'd3;
        end
      end
      dab = {dab[BCD_W-2:0], sh_r[SH_W-1-b]};
    end
  end

  // sequencing
  always_comb begin
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    neg_nxt  = neg_r;
    if (done_r && dn_ready) begin
      done_nxt = 1'b0;
    end
    if (load) begin
      sh_nxt   = SH_W'(in_mag);
      bcd_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
      neg_nxt  = in_neg;
    end else if (busy_r) begin
      bcd_nxt  = dab;
      sh_nxt   = sh_r << STEP_BITS;
      step_nxt = step_r + 1'b1;
      if (step_r == CNT_W'(STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/s2d_emit.sv =====
// Character emitter: sends the sign and the significant BCD digits, most
// significant first, through an output register. Depends on s2d_pkg.
`default_nettype none
module s2d_emit #(
  parameter int NDIG = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        dn_valid,
  output logic                             dn_ready,
  input  wire logic                        dn_neg,
  input  wire logic [NDIG*4-1:0]           dn_bcd,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [s2d_pkg::CHAR_W-1:0]       out_char,
  output logic                             out_last
);
  import s2d_pkg::*;

  localparam int BCD_W = NDIG * DIGIT_BITS;
  localparam int IDX_W = $clog2(NDIG);

  emit_state_t       state_r, state_nxt;
  logic [BCD_W-1:0]  dig_r, dig_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              vld_r, vld_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              last_r, last_nxt;
  logic [IDX_W-1:0]  lead;
  logic [DIGIT_BITS-1:0] cur_dig;
  logic              out_free;

  assign out_valid = vld_r;
  assign out_char  = char_r;
  assign out_last  = last_r;
  assign out_free  = !vld_r || out_ready;
  assign cur_dig   = dig_r[idx_r*DIGIT_BITS +: DIGIT_BITS];

  // position of the leading nonzero digit (zero for the value zero)
  always_comb begin
    lead = '0;
    for (int d = 0; d < NDIG; d++) begin
      if (dn_bcd[d*DIGIT_BITS +: DIGIT_BITS] != '0) begin
        lead = IDX_W'(d);
      end
    end
  end

  // next state and output register
  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    idx_nxt   = idx_r;
    vld_nxt   = vld_r && !out_ready;
    char_nxt  = char_r;
    last_nxt  = last_r;
    dn_ready  = 1'b0;
    unique case (state_r)
      EM_IDLE: begin
        dn_ready = 1'b1;
        if (dn_valid) begin
          dig_nxt   = dn_bcd;
          idx_nxt   = lead;
          state_nxt = dn_neg ? EM_SIGN : EM_DIGITS;
        end
      end
      EM_SIGN: begin
        if (out_free) begin
          vld_nxt   = 1'b1;
          char_nxt  = ASCII_MINUS;
          last_nxt  = 1'b0;
          state_nxt = EM_DIGITS;
        end
      end
      EM_DIGITS: begin
        if (out_free) begin
          vld_nxt  = 1'b1;
          char_nxt = ASCII_ZERO + CHAR_W'(cur_dig);
          last_nxt = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = EM_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = EM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= EM_IDLE;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r  <= dig_nxt;
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/signed_int_to_decimal_ascii.sv =====
// Signed integer to decimal ASCII text. Each input beat carries one
// VALUE_BITS-bit two's complement integer; the block sends its decimal text
// as one output beat per character, most significant first, with a leading
// minus for negative values, '0' for zero, and tlast on the final character.
// An input beat enters a two-entry queue; the binary to BCD converter then
// works through the magnitude STEP_BITS bits at a time, overlapped with
// the emitter, which sends one character per cycle while the output is not
// stalled and returns to its idle state to load the next number.
// Depends on s2d_pkg, s2d_front, s2d_bcd, s2d_emit and the defines header.
`default_nettype none
`include "signed_int_to_decimal_ascii_defines.svh"
module signed_int_to_decimal_ascii #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // [VALUE_BITS-1:0] value, zero filled to whole bytes
  input  wire logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // [5:0] character, [7:6] zero
  output logic [7:0]                                out_tdata,
  output logic                                      out_tlast
);
  import s2d_pkg::*;

  localparam int NDIG = (VALUE_BITS * 3) / 10 + 1;

  logic                  q_valid, q_ready, q_neg;
  logic [VALUE_BITS-1:0] q_mag;
  logic                  dn_valid, dn_ready, dn_neg;
  logic [NDIG*4-1:0]     dn_bcd;
  logic [CHAR_W-1:0]     out_char;
  logic                  is_minus;
  logic                  is_digit;

  // sign/magnitude split and queue
  s2d_front #(.VALUE_BITS(VALUE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_value (in_tdata[VALUE_BITS-1:0]),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_neg    (q_neg),
    .q_mag    (q_mag)
  );

  // magnitude to BCD digits
  s2d_bcd #(.VALUE_BITS(VALUE_BITS), .NDIG(NDIG)) u_bcd (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (q_valid),
    .in_ready (q_ready),
    .in_neg   (q_neg),
    .in_mag   (q_mag),
    .dn_valid (dn_valid),
    .dn_ready (dn_ready),
    .dn_neg   (dn_neg),
    .dn_bcd   (dn_bcd)
  );

  // character stream
  s2d_emit #(.NDIG(NDIG)) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .dn_valid  (dn_valid),
    .dn_ready  (dn_ready),
    .dn_neg    (dn_neg),
    .dn_bcd    (dn_bcd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast)
  );

  assign out_tdata = {2'b00, out_char};

  // character classes for the checks below
  assign is_minus = (out_char == ASCII_MINUS);
  assign is_digit = (out_char >= ASCII_ZERO) && (out_char <= ASCII_ZERO + 6'd9);

  // a minus sign never ends a run
  `S2D_ASSERT_SAME(a_minus_not_last, clk, rst_n, out_tvalid && is_minus, !out_tlast)
  // only a minus sign or a decimal digit is ever sent
  `S2D_ASSERT_SAME(a_char_range, clk, rst_n, out_tvalid, is_minus || is_digit)
  // a valid character follows the minus sign at once
  `S2D_ASSERT_NEXT(a_minus_then_digit, clk, rst_n, out_tvalid && out_tready && is_minus, out_tvalid)

endmodule
`default_nettype wire

// ===== tb/decimal_text_checker.sv =====
// Checker for the signed integer to decimal text block: watches both streams,
// predicts each number's characters and compares them beat by beat.
// Depends on s2d_pkg for the character width and ASCII codes.
`timescale 1ns / 100ps
module decimal_text_checker #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_tvalid,
  input  wire logic                                    in_tready,
  // [VALUE_BITS-1:0] value, zero filled to whole bytes
  input  wire logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  input  wire logic                                    out_tvalid,
  input  wire logic                                    out_tready,
  // [5:0] character, [7:6] zero
  input  wire logic [7:0]                              out_tdata,
  input  wire logic                                    out_tlast,
  output int                                           errors,
  output int                                           pending
);
  import s2d_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // characters still owed by the block, oldest first
  text_char_t expected_chars[$];
  text_char_t want;

  task automatic report_mismatch(input string what);
    if (errors < 25) $display("decimal_text_checker: %s at %0t", what, $time);
    errors++;
  endtask

  // Decimal text of one value: sign first, digits most significant first.
  // The magnitude is taken unsigned, so the most negative value converts too.
  function automatic void append_text(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS-1:0] mag;
    logic [3:0]            digits[$];
    text_char_t            c;
    int                    k;
    mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
    do begin
      digits.push_back(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (value[VALUE_BITS-1]) begin
      c.code = ASCII_MINUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
    end
    for (k = digits.size() - 1; k >= 0; k--) begin
      c.code = ASCII_ZERO + CHAR_W'(digits[k]);
      c.last = (k == 0);
      expected_chars.push_back(c);
    end
  endfunction

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) append_text(in_tdata[VALUE_BITS-1:0]);
      if (out_tvalid && out_tready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected beat char %0d last %0b",
                                    out_tdata[CHAR_W-1:0], out_tlast));
        end else begin
          want = expected_chars.pop_front();
          if (out_tdata[CHAR_W-1:0] !== want.code)
            report_mismatch($sformatf("char %0d, want %0d",
                                      out_tdata[CHAR_W-1:0], want.code));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("tlast %0b, want %0b", out_tlast, want.last));
        end
      end
    end
    pending <= expected_chars.size();
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the signed integer to decimal text block: clock, reset,
// number stimulus with random idling on both streams, and the verdict.
// Depends on signed_int_to_decimal_ascii and decimal_text_checker.
`timescale 1ns / 100ps
module tb;

  localparam int VALUE_BITS = 32;
  localparam int DATA_W     = ((VALUE_BITS + 7) / 8) * 8;
  localparam int RANDOM_NUMBERS = 390;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [7:0]        out_tdata;
  logic              out_tlast;
  int                errors;
  int                pending;
  logic              steady;
  int                stall_left;

  // Edges of the range, digit count steps, sign flips
  logic [VALUE_BITS-1:0] directed_values [22] = '{
    32'd0, 32'd1, 32'hFFFFFFFF, 32'd9, 32'd10, 32'(-9), 32'(-10), 32'd99,
    32'd100, 32'(-100), 32'd12345, 32'(-67890), 32'd999999999, 32'd1000000000,
    32'(-1000000000), 32'h7FFFFFFF, 32'h80000001, 32'h80000000, 32'h55555555,
    32'hAAAAAAAA, 32'd1234567890, 32'(-2147483600)
  };

  signed_int_to_decimal_ascii #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  decimal_text_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run
  initial begin
    #15000000;
    $display("tb: errors");
    $finish;
  end

  // Idle length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint pow10(input int d);
    longint p;
    p = 1;
    repeat (d) p = p * 10;
    return p;
  endfunction

  // Random number: full range, chosen digit counts, powers of ten, tiny, extremes
  function automatic logic [VALUE_BITS-1:0] random_value();
    longint v;
    longint lo;
    longint hi;
    int     d;
    case ($urandom_range(0, 5))
      0, 1: v = longint'($urandom);
      2: begin
        d  = $urandom_range(1, 10);
        lo = (d == 1) ? 0 : pow10(d - 1);
        hi = pow10(d) - 1;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        v  = lo + (longint'($urandom) % (hi - lo + 1));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      3: begin
        v = pow10($urandom_range(1, 9)) + $urandom_range(0, 2) - 1;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      4: v = longint'($urandom_range(0, 40)) - 20;
      default: begin
        if ($urandom_range(0, 1) == 1) v = 64'sd2147483647 - $urandom_range(0, 3);
        else v = -64'sd2147483648 + $urandom_range(0, 3);
      end
    endcase
    return v[VALUE_BITS-1:0];
  endfunction

  // Present one number, optionally after an idle gap, and hold until taken
  task automatic send_value(input logic [VALUE_BITS-1:0] v);
    int n;
    n = (steady || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_W'(v);
    do @(posedge clk); while (!in_tready);
  endtask

  // Output backpressure: random stalls, none started while steady
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (!steady && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    steady     = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_values[i]) send_value(directed_values[i]);

    for (int i = 0; i < RANDOM_NUMBERS; i++) begin
      steady <= ((i % 64) < 12);
      send_value(random_value());
    end
    in_tvalid <= 1'b0;
    steady    <= 1'b0;

    // Drain: let the checker see the last push, then wait for every character
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);

    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/s2d_pkg.sv
sv/s2d_front.sv
sv/s2d_bcd.sv
sv/s2d_emit.sv
sv/signed_int_to_decimal_ascii.sv
tb/decimal_text_checker.sv
tb/tb.sv
